FILE: rtl/efil_pkg.sv
// ----------------------------------------------------------------------------
// efil_pkg: shared types and constants of the 5x5 edge filter
// Pixel type, window geometry, kernel magnitudes and config register indexes.
// ----------------------------------------------------------------------------
package efil_pkg;

    localparam int PIX_W      = 8;
    localparam int WIN_ROWS   = 5;
    localparam int WIN_COLS   = 4;   // stored columns; the fifth is the live column
    localparam int LINES      = 4;   // line stores, one per earlier row
    localparam int MIN_DIM    = 5;   // smallest usable width or height
    localparam int FIRST_OUT  = 4;   // first row/column that completes a window

    // kernel magnitudes; outer taps are subtracted, the center is added
    localparam int K_TOP_BOT  = 7;
    localparam int K_SIDE     = 5;
    localparam int K_CENTER   = 90;
    localparam int PIX_MAX    = 255;

    // config port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 8'd1;

    typedef logic [PIX_W-1:0] t_pix;

    // one window column, index 0 = oldest row
    typedef t_pix [WIN_ROWS-1:0] t_colpx;

endpackage

FILE: rtl/efil_ram.sv
// ----------------------------------------------------------------------------
// efil_ram: generic simple dual-port RAM
// One write port, one read port, registered read data held while not enabled.
// ----------------------------------------------------------------------------
module efil_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/efil_conv.sv
// ----------------------------------------------------------------------------
// efil_conv: 5x4 window registers and the saturated 5x5 kernel sum
// Window shifts left by one column on each shift strobe; sum is combinational.
// ----------------------------------------------------------------------------
module efil_conv (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  efil_pkg::t_colpx i_col,
    output efil_pkg::t_pix  o_value
);

    import efil_pkg::*;

    t_pix r_win [WIN_ROWS][WIN_COLS];

    logic [11:0] sum_tb;    // top and bottom rows, up to 10 * 255
    logic [10:0] sum_side;  // left and right taps of middle rows, up to 6 * 255
    logic [14:0] pos_part;
    logic [14:0] neg_part;
    logic [14:0] diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_ROWS; i++) begin
                for (int j = 0; j < WIN_COLS; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (i_shift) begin
            for (int i = 0; i < WIN_ROWS; i++) begin
                for (int j = 0; j < WIN_COLS - 1; j++) begin
                    r_win[i][j] <= r_win[i][j+1];
                end
                r_win[i][WIN_COLS-1] <= i_col[i];
            end
        end
    end

    always_comb begin
        sum_tb = 12'(i_col[0]) + 12'(i_col[WIN_ROWS-1]);
        for (int j = 0; j < WIN_COLS; j++) begin
            sum_tb = sum_tb + 12'(r_win[0][j]) + 12'(r_win[WIN_ROWS-1][j]);
        end
        sum_side = '0;
        for (int i = 1; i < WIN_ROWS - 1; i++) begin
            sum_side = sum_side + 11'(r_win[i][0]) + 11'(i_col[i]);
        end
        pos_part = 15'(r_win[2][2]) * 15'(K_CENTER);
        neg_part = 15'(sum_tb) * 15'(K_TOP_BOT) + 15'(sum_side) * 15'(K_SIDE);
        diff     = pos_part - neg_part;
        // clamp to 0..255
        if (neg_part >= pos_part) begin
            o_value = '0;
        end else if (diff > 15'(PIX_MAX)) begin
            o_value = t_pix'(PIX_MAX);
        end else begin
            o_value = diff[PIX_W-1:0];
        end
    end

endmodule

FILE: rtl/edge_filter_5x5_top.sv
// ----------------------------------------------------------------------------
// edge_filter_5x5_top: streaming 5x5 edge filter, one pixel per clock unless stalled
// Result path: pixel (r, c) passes the stage 1 register, then the output register.
// Throughput: one pixel per cycle while the consumer does not stall interior results.
// Reset: sync active-low; clears position, window, pipeline; 512x512 config.
// ----------------------------------------------------------------------------
//
// Pipeline
//   accept : position tracking decides whether this pixel closes an interior
//            window and whether it is the last one; the line RAM is read at
//            the pixel's column.
//   stage 1: pixel, column and flags held with the RAM read data (four older
//            rows of the same column). The kernel sum is formed from the
//            window plus this live column. When stage 1 moves on, the window
//            shifts and the column is written back with the new pixel pushed
//            in as the newest row.
//   output : result register feeding the master side.
//
// A pixel that closes no interior window leaves stage 1 without waiting for
// the output register, so border pixels never stall on a busy consumer.
//
// Line RAM: MAX_COLS entries of four packed pixels, newest row in the low
// byte. Contents are undefined after reset; every column read for an emitted
// result was written earlier in the same image, so no clearing is needed.
// Consecutive pixels always hit different columns (width is at least 5), so
// the read of one pixel never collides with the write-back of the previous.
//
// Config writes are taken at any time and apply at once; the position is kept.
module edge_filter_5x5_top #(
    parameter int MAX_COLS = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [efil_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [efil_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // pixel input
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [7:0]                        i_s_tdata,  // [7:0] pixel
    // result output
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [7:0]                        o_m_tdata,  // [7:0] edge_value
    output logic                              o_m_tlast   // frame_last
);

    import efil_pkg::*;

    localparam int CW = $clog2(MAX_COLS);              // column index bits
    localparam int WW = (CW + 1 > 10) ? CW + 1 : 10;   // width compare bits
    localparam int RAM_W = LINES * PIX_W;

    // config registers
    logic [9:0]  r_width;
    logic [11:0] r_height;

    // position of the next pixel
    logic [CW-1:0] r_col;
    logic [11:0]   r_row;
    logic [CW-1:0] n_col;
    logic [11:0]   n_row;

    // stage 1
    logic          r_s1_vld;
    t_pix          r_s1_pix;
    logic [CW-1:0] r_s1_col;
    logic          r_s1_emit;
    logic          r_s1_last;

    // output register
    logic          r_out_vld;
    t_pix          r_out_val;
    logic          r_out_last;

    logic [WW-1:0] w_raw;
    logic [WW-1:0] w_eff;
    logic [11:0]   h_eff;
    logic [WW-1:0] c_ext;
    logic [WW-1:0] c_inc;
    logic [12:0]   row_inc;
    logic          emit;
    logic          last;
    logic          s_acc;
    logic          s1_go;
    logic          out_free;
    logic [RAM_W-1:0] ram_rd;
    t_colpx        col_px;
    t_pix          conv_val;

    // ---------------- config ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 10'd512;
            r_height <= 12'd512;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_WIDTH) begin
                r_width <= i_cfg_data[9:0];
            end else if (i_cfg_index == CFG_HEIGHT) begin
                r_height <= i_cfg_data[11:0];
            end
        end
    end

    // effective sizes: width clamped to 5..MAX_COLS, height at least 5
    assign w_raw = WW'(r_width);
    assign w_eff = (w_raw < WW'(MIN_DIM))  ? WW'(MIN_DIM)  :
                   (w_raw > WW'(MAX_COLS)) ? WW'(MAX_COLS) : w_raw;
    assign h_eff = (r_height < 12'(MIN_DIM)) ? 12'(MIN_DIM) : r_height;

    // ---------------- handshake ----------------
    assign out_free   = !r_out_vld || i_m_tready;
    assign s1_go      = r_s1_vld && (out_free || !r_s1_emit);
    assign o_s_tready = !r_s1_vld || s1_go;
    assign s_acc      = i_s_tvalid && o_s_tready;

    // ---------------- position ----------------
    assign c_ext   = WW'(r_col);
    assign c_inc   = c_ext + WW'(1);
    assign row_inc = {1'b0, r_row} + 13'd1;

    // interior test: a full 5x5 window ends at this pixel
    assign emit = (r_row >= 12'(FIRST_OUT)) && (c_ext >= WW'(FIRST_OUT)) &&
                  (r_row < h_eff) && (c_ext < w_eff);
    assign last = (r_row == h_eff - 12'd1) && (c_ext == w_eff - WW'(1));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (c_inc >= w_eff) begin
            // end of row; also covers a column beyond a shrunken width
            n_col = '0;
            n_row = (row_inc >= {1'b0, h_eff}) ? 12'd0 : row_inc[11:0];
        end else begin
            n_col = c_inc[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (s_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- stage 1 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_go) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_pix  <= i_s_tdata;
            r_s1_col  <= r_col;
            r_s1_emit <= emit;
            r_s1_last <= last;
        end
    end

    // line RAM: read at accept, write back the pushed column when stage 1 leaves
    efil_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_COLS)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_s1_col),
        .i_wdata ({ram_rd[RAM_W-PIX_W-1:0], r_s1_pix}),
        .i_re    (s_acc),
        .i_raddr (r_col),
        .o_rdata (ram_rd)
    );

    // live column, oldest row first
    always_comb begin
        for (int k = 0; k < LINES; k++) begin
            col_px[k] = ram_rd[(LINES-1-k)*PIX_W +: PIX_W];
        end
        col_px[WIN_ROWS-1] = r_s1_pix;
    end

    efil_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (s1_go),
        .i_col   (col_px),
        .o_value (conv_val)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_go && r_s1_emit) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_emit) begin
            r_out_val  <= conv_val;
            r_out_last <= r_s1_last;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_val;
    assign o_m_tlast  = r_out_last;

`ifndef ASSERT_OFF
    // a new result appears only from an interior pixel leaving stage 1
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_s1_vld && r_s1_emit))
        else $error("result without interior pixel");

    // the last flag is only ever set on an emitted pixel
    a_last_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1_last) |-> r_s1_emit)
        else $error("frame_last on non-interior pixel");

    // column index stays inside the line RAM
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_col} < (CW+1)'(MAX_COLS)))
        else $error("column beyond line RAM depth");

    // input stalls only when stage 1 is blocked behind a full output register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_s1_vld && r_s1_emit && r_out_vld && !i_m_tready))
        else $error("input stalled without cause");
`endif

endmodule
